[src/bgci_pkg.sv]
`default_nettype none

package bgci_pkg;

    // field widths
    localparam int ADC_W      = 10;
    localparam int VOLT_W     = 10;
    localparam int PCT_W      = 7;
    localparam int INTERVAL_W = 8;
    localparam int CHG_CNT_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // (voltage - empty) * 100 tops out at 584 * 100
    localparam int NUM_W = 16;

    // voltage = adc * 585 / 1024
    localparam logic [ADC_W-1:0] VOLT_SCALE = 10'd585;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    localparam int CHG_BLINK_BIT = 6;

    // double blink points within the low-battery period
    localparam int BLINK_ON_FIRST   = 50;
    localparam int BLINK_OFF_FIRST  = 150;
    localparam int BLINK_ON_SECOND  = 250;
    localparam int BLINK_OFF_SECOND = 350;

    localparam int LOW_BLINK_PERIOD_DEF = 3000;
    localparam int LOW_COUNT_LIMIT_DEF  = 10;

    localparam logic [VOLT_W-1:0]     EMPTY_LEVEL_RST = 10'd340;
    localparam logic [VOLT_W-1:0]     FULL_LEVEL_RST  = 10'd420;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST    = 8'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EMPTY_LEVEL     = 2'd0,
        CFG_FULL_LEVEL      = 2'd1,
        CFG_SAMPLE_INTERVAL = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FINISH
    } t_state;

    // handshake between the sequencer and a serial arithmetic unit
    typedef struct packed {
        logic start;
    } t_unit_req;

    typedef struct packed {
        logic done;
    } t_unit_rsp;

endpackage

`default_nettype wire

[src/bgci_in_if.sv]
`default_nettype none

interface bgci_in_if import bgci_pkg::*; ;
    logic             valid;
    logic             ready;
    logic             vin_present;
    logic             charge_done;
    logic [ADC_W-1:0] adc_sample;
    logic             link_connected;
    logic             notify_request;

    modport source (
        output valid, vin_present, charge_done, adc_sample, link_connected, notify_request,
        input  ready
    );
    modport sink (
        input  valid, vin_present, charge_done, adc_sample, link_connected, notify_request,
        output ready
    );
endinterface

`default_nettype wire

[src/bgci_out_if.sv]
`default_nettype none

interface bgci_out_if import bgci_pkg::*; ;
    logic              valid;
    logic              ready;
    logic              led_on;
    logic [PCT_W-1:0]  battery_percent;
    logic              charging_now;
    logic              power_low;
    logic              sample_taken;
    logic [VOLT_W-1:0] battery_voltage;
    logic              notify_pulse;

    modport source (
        output valid, led_on, battery_percent, charging_now, power_low, sample_taken,
               battery_voltage, notify_pulse,
        input  ready
    );
    modport sink (
        input  valid, led_on, battery_percent, charging_now, power_low, sample_taken,
               battery_voltage, notify_pulse,
        output ready
    );
endinterface

`default_nettype wire

[src/bgci_cfg_if.sv]
`default_nettype none

interface bgci_cfg_if import bgci_pkg::*; ;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/bgci_mul.sv]
`default_nettype none

// Bit-serial multiply by VOLT_SCALE, one multiplier bit per cycle, keeping
// only the upper half of the product (the >> 10 comes for free).
module bgci_mul import bgci_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_unit_req         i_req,
    input  wire logic [ADC_W-1:0]  i_adc,
    output t_unit_rsp              o_rsp,
    output logic [VOLT_W-1:0]      o_volt
);

    localparam int CNT_W = $clog2(ADC_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [ADC_W-1:0] r_coef, n_coef;
    logic [ADC_W-1:0] r_mcand, n_mcand;
    logic [ADC_W-1:0] r_hi, n_hi;
    logic [ADC_W:0]   sum;

    always_comb begin
        sum     = {1'b0, r_hi} + (r_coef[0] ? {1'b0, r_mcand} : '0);
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_coef  = r_coef;
        n_mcand = r_mcand;
        n_hi    = r_hi;
        if (i_req.start) begin
            n_busy  = 1'b1;
            n_cnt   = '0;
            n_coef  = VOLT_SCALE;
            n_mcand = i_adc;
            n_hi    = '0;
        end else if (r_busy) begin
            n_hi   = sum[ADC_W:1];
            n_coef = {1'b0, r_coef[ADC_W-1:1]};
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(ADC_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt   <= n_cnt;
        r_coef  <= n_coef;
        r_mcand <= n_mcand;
        r_hi    <= n_hi;
    end

    assign o_rsp.done = r_done;
    assign o_volt     = r_hi;

endmodule

`default_nettype wire

[src/bgci_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module bgci_div import bgci_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_unit_req         i_req,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [VOLT_W-1:0] i_den,
    output t_unit_rsp              o_rsp,
    output logic [NUM_W-1:0]       o_quo
);

    localparam int CNT_W = $clog2(NUM_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [VOLT_W-1:0] r_den, n_den;
    logic [VOLT_W-1:0] r_rem, n_rem;
    logic [NUM_W-1:0]  r_quo, n_quo;
    logic [VOLT_W:0]   trial;
    logic              fits;

    always_comb begin
        trial  = {r_rem, r_quo[NUM_W-1]};
        fits   = (trial >= {1'b0, r_den});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_den  = r_den;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_den  = i_den;
            n_rem  = '0;
            n_quo  = i_num;
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits VOLT_W bits
            n_rem = fits ? VOLT_W'(trial - {1'b0, r_den}) : trial[VOLT_W-1:0];
            n_quo = {r_quo[NUM_W-2:0], fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_den <= n_den;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_rsp.done = r_done;
    assign o_quo      = r_quo;

endmodule

`default_nettype wire

[src/battery_gauge_charge_indicator.sv]
`default_nettype none

// Channel   Dir  Payload                                             Accept
// i_in      in   vin_present charge_done adc_sample link notify_req  valid & ready
// o_out     out  led_on battery_percent charging_now power_low       valid & ready
//                sample_taken battery_voltage notify_pulse
// i_cfg     in   index (2b) data (10b)                               valid & ready
//
// One tick per transaction. A non-sampling tick goes through accept and
// result load. A sampling tick goes through accept, the 10-step bit-serial
// multiply by 585, the 16-step restoring divide for the percentage, and
// result load; the divide is skipped below empty or with no span.
// i_in is ready only while the sequencer is idle; a finished result waits
// in its own state if o_out is still full, so o_out stalls hold the input.
// Reset (i_rst_n, synchronous) clears gauge state but r_link and r_prev_level, and restores config.
module battery_gauge_charge_indicator import bgci_pkg::*; #(
    parameter int LOW_BLINK_PERIOD = LOW_BLINK_PERIOD_DEF,
    parameter int LOW_COUNT_LIMIT  = LOW_COUNT_LIMIT_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bgci_in_if.sink    i_in,
    bgci_out_if.source o_out,
    bgci_cfg_if.sink   i_cfg
);

    // low blink counter saturates at period+1, low sample count at limit+1
    localparam int LB_W = $clog2(LOW_BLINK_PERIOD + 2);
    localparam int LS_W = $clog2(LOW_COUNT_LIMIT + 2);

    // ---------------- configuration ----------------
    logic [VOLT_W-1:0]     r_empty;
    logic [VOLT_W-1:0]     r_full;
    logic [INTERVAL_W-1:0] r_interval;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty    <= EMPTY_LEVEL_RST;
            r_full     <= FULL_LEVEL_RST;
            r_interval <= INTERVAL_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_EMPTY_LEVEL:     r_empty    <= i_cfg.data;
                CFG_FULL_LEVEL:      r_full     <= i_cfg.data;
                CFG_SAMPLE_INTERVAL: r_interval <= i_cfg.data[INTERVAL_W-1:0];
                default:             ;
            endcase
        end
    end

    // ---------------- gauge state ----------------
    t_state                r_state, n_state;
    logic                  r_led, n_led;
    logic                  r_seen, n_seen;
    logic                  r_seen_before, n_seen_before;
    logic [CHG_CNT_W-1:0]  r_chg_cnt, n_chg_cnt;
    logic [INTERVAL_W-1:0] r_tick_cnt, n_tick_cnt;
    logic [LB_W-1:0]       r_lb_cnt, n_lb_cnt;
    logic [LS_W-1:0]       r_ls_cnt, n_ls_cnt;
    logic                  r_flag, n_flag;
    logic [PCT_W-1:0]      r_level, n_level;
    logic [VOLT_W-1:0]     r_volt, n_volt;
    logic                  r_waiting, n_waiting;
    logic                  r_link, n_link;
    logic [PCT_W-1:0]      r_prev_level, n_prev_level;
    logic                  r_sampled, n_sampled;

    // output register
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_led;
    logic [PCT_W-1:0]      r_out_pct;
    logic                  r_out_chg;
    logic                  r_out_low;
    logic                  r_out_smp;
    logic [VOLT_W-1:0]     r_out_volt;
    logic                  r_out_pulse;
    logic                  load_out;
    logic                  pulse;

    // serial units
    t_unit_req             mul_req, div_req;
    t_unit_rsp             mul_rsp, div_rsp;
    logic [VOLT_W-1:0]     mul_volt;
    logic [NUM_W-1:0]      div_num;
    logic [VOLT_W-1:0]     div_den;
    logic [VOLT_W-1:0]     div_diff;
    logic [NUM_W-1:0]      div_quo;

    bgci_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .i_adc   (i_in.adc_sample),
        .o_rsp   (mul_rsp),
        .o_volt  (mul_volt)
    );

    bgci_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_rsp   (div_rsp),
        .o_quo   (div_quo)
    );

    // scaled voltage is at or above empty whenever the divide runs
    assign div_diff = mul_volt - r_empty;
    assign div_num  = NUM_W'(div_diff) * NUM_W'(PCT_FULL);
    assign div_den  = r_full - r_empty;

    assign i_in.ready = (r_state == ST_IDLE);

    always_comb begin
        n_state       = r_state;
        n_led         = r_led;
        n_seen        = r_seen;
        n_seen_before = r_seen_before;
        n_chg_cnt     = r_chg_cnt;
        n_tick_cnt    = r_tick_cnt;
        n_lb_cnt      = r_lb_cnt;
        n_ls_cnt      = r_ls_cnt;
        n_flag        = r_flag;
        n_level       = r_level;
        n_volt        = r_volt;
        n_waiting     = r_waiting;
        n_link        = r_link;
        n_prev_level  = r_prev_level;
        n_sampled     = r_sampled;
        mul_req.start = 1'b0;
        div_req.start = 1'b0;
        load_out      = 1'b0;
        pulse         = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_waiting    = r_waiting | i_in.notify_request;
                    n_link       = i_in.link_connected;
                    n_prev_level = r_level;

                    // charge step: plug-in clears the low flag
                    n_seen_before = r_seen;
                    n_seen        = i_in.vin_present;
                    if (!r_seen && i_in.vin_present) begin
                        n_flag = 1'b0;
                    end
                    if (i_in.vin_present) begin
                        if (i_in.charge_done) begin
                            n_led = 1'b0;
                        end else begin
                            n_chg_cnt = r_chg_cnt + 1'b1;
                            n_led     = n_chg_cnt[CHG_BLINK_BIT];
                        end
                    end

                    // low battery double blink
                    if (r_lb_cnt <= LB_W'(LOW_BLINK_PERIOD)) begin
                        n_lb_cnt = r_lb_cnt + 1'b1;
                    end
                    if (!n_seen && n_flag) begin
                        if (n_lb_cnt > LB_W'(LOW_BLINK_PERIOD)) begin
                            n_lb_cnt = '0;
                        end
                        if (n_lb_cnt == LB_W'(BLINK_ON_FIRST) ||
                            n_lb_cnt == LB_W'(BLINK_ON_SECOND)) begin
                            n_led = 1'b1;
                        end
                        if (n_lb_cnt == LB_W'(BLINK_OFF_FIRST) ||
                            n_lb_cnt == LB_W'(BLINK_OFF_SECOND)) begin
                            n_led = 1'b0;
                        end
                    end

                    // sample schedule
                    if (r_tick_cnt >= r_interval) begin
                        n_tick_cnt    = '0;
                        n_sampled     = 1'b1;
                        mul_req.start = 1'b1;
                        n_state       = ST_MUL;
                    end else begin
                        n_tick_cnt = r_tick_cnt + 1'b1;
                        n_sampled  = 1'b0;
                        n_state    = ST_FINISH;
                    end
                end
            end

            ST_MUL: begin
                if (mul_rsp.done) begin
                    n_volt = mul_volt;
                    if (mul_volt < r_empty) begin
                        n_level = '0;
                        if (r_ls_cnt <= LS_W'(LOW_COUNT_LIMIT)) begin
                            n_ls_cnt = r_ls_cnt + 1'b1;
                        end
                        if (n_ls_cnt > LS_W'(LOW_COUNT_LIMIT)) begin
                            n_flag = 1'b1;
                        end
                        n_state = ST_FINISH;
                    end else begin
                        n_ls_cnt = '0;
                        n_flag   = 1'b0;
                        if (r_full <= r_empty) begin
                            // no span: anything at or above empty is full
                            n_level = PCT_FULL;
                            n_state = ST_FINISH;
                        end else begin
                            div_req.start = 1'b1;
                            n_state       = ST_DIV;
                        end
                    end
                end
            end

            ST_DIV: begin
                if (div_rsp.done) begin
                    n_level = (div_quo > NUM_W'(PCT_FULL)) ? PCT_FULL : div_quo[PCT_W-1:0];
                    n_state = ST_FINISH;
                end
            end

            ST_FINISH: begin
                if (!r_out_valid || o_out.ready) begin
                    load_out = 1'b1;
                    pulse    = r_sampled && r_link &&
                               (r_prev_level != r_level || r_seen_before != r_seen ||
                                r_waiting);
                    if (pulse) begin
                        n_waiting = 1'b0;
                    end
                    n_state = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase

        n_out_valid = r_out_valid;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_led         <= 1'b0;
            r_seen        <= 1'b0;
            r_seen_before <= 1'b0;
            r_chg_cnt     <= '0;
            r_tick_cnt    <= '0;
            r_lb_cnt      <= '0;
            r_ls_cnt      <= '0;
            r_flag        <= 1'b0;
            r_level       <= '0;
            r_volt        <= '0;
            r_waiting     <= 1'b0;
            r_sampled     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_led         <= n_led;
            r_seen        <= n_seen;
            r_seen_before <= n_seen_before;
            r_chg_cnt     <= n_chg_cnt;
            r_tick_cnt    <= n_tick_cnt;
            r_lb_cnt      <= n_lb_cnt;
            r_ls_cnt      <= n_ls_cnt;
            r_flag        <= n_flag;
            r_level       <= n_level;
            r_volt        <= n_volt;
            r_waiting     <= n_waiting;
            r_sampled     <= n_sampled;
            r_out_valid   <= n_out_valid;
        end
        r_link       <= n_link;
        r_prev_level <= n_prev_level;
    end

    // result payload, loaded once per tick
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_led   <= r_led;
            r_out_pct   <= r_level;
            r_out_chg   <= r_seen;
            r_out_low   <= r_flag;
            r_out_smp   <= r_sampled;
            r_out_volt  <= r_volt;
            r_out_pulse <= pulse;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.led_on          = r_out_led;
    assign o_out.battery_percent = r_out_pct;
    assign o_out.charging_now    = r_out_chg;
    assign o_out.power_low       = r_out_low;
    assign o_out.sample_taken    = r_out_smp;
    assign o_out.battery_voltage = r_out_volt;
    assign o_out.notify_pulse    = r_out_pulse;

endmodule

`default_nettype wire
